// ----- rtl/bcss_pkg.sv -----
package bcss_pkg;

	// register indexes
	localparam logic [2:0] REG_BALL_COUNT = 3'd0;
	localparam logic [2:0] REG_FIELD_W    = 3'd1;
	localparam logic [2:0] REG_FIELD_H    = 3'd2;
	localparam logic [2:0] REG_MARGIN     = 3'd3;
	localparam logic [2:0] REG_CONTACT    = 3'd4;

	localparam logic [5:0]  RST_BALL_COUNT = 6'd32;
	localparam logic [9:0]  RST_FIELD_W    = 10'd640;
	localparam logic [9:0]  RST_FIELD_H    = 10'd480;
	localparam logic [7:0]  RST_MARGIN     = 8'd21;
	localparam logic [15:0] RST_CONTACT    = 16'd1600;

	// input modes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [24:0] POS_MAX      = 25'd26188799;
	localparam logic [14:0] SUB_PER_PIX  = 15'd25600;
	localparam logic [29:0] SUB_PER_PIX2 = 30'd655360000;

	// quotient bits of the rounding divide
	localparam int QB = 20;

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767) r = 16'sh7fff;
		else if (v < -22'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v == 16'sh8000) r = 16'sh7fff;
		else r = -v;
		return r;
	endfunction

	function automatic logic [24:0] clamp_pos(input logic signed [26:0] v);
		logic [24:0] r;
		if (v < 27'sd0) r = '0;
		else if (v > $signed({2'b00, POS_MAX})) r = POS_MAX;
		else r = v[24:0];
		return r;
	endfunction

endpackage

// ----- rtl/ball_collision_sim_step_core.sv -----
// Channel   | handshake                 | word
// ----------+---------------------------+-------------------------------------------
// input     | in_valid / in_stall       | mode, ball_index, load_pos_*, load_vel_*
// output    | out_valid / out_stall     | read_index, read_pos_*, read_vel_*
// config    | APB psel/penable/pwrite   | five registers at byte address 4*i
//
// A load is written from the idle state; a read waits for the output register to free.
// A tick walks every disc pair, dropping those out of contact, then does a wall and
// move pass per disc; a pair in contact goes through the shared restoring divider
// (20 steps), and the single write port of the velocity memory writes disc i, then j.
// Reset clears control and valid bits; a disc entry never written reads as zero.
// in_stall is high while a tick or a read is in progress; a waiting output word does
// not block loads or ticks.
module ball_collision_sim_step_core
	import bcss_pkg::*;
#(
	parameter int MAX_DISCS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [4:0]         ball_index,
	input  logic [24:0]        load_pos_x,
	input  logic [24:0]        load_pos_y,
	input  logic signed [15:0] load_vel_x,
	input  logic signed [15:0] load_vel_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         read_index,
	output logic [24:0]        read_pos_x,
	output logic [24:0]        read_pos_y,
	output logic signed [15:0] read_vel_x,
	output logic signed [15:0] read_vel_y
);

	localparam int AW = (MAX_DISCS > 2) ? $clog2(MAX_DISCS) : 1;
	localparam int CW = $clog2(MAX_DISCS + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_TS   = 4'd2;
	localparam logic [3:0] S_PA   = 4'd3;
	localparam logic [3:0] S_PB   = 4'd4;
	localparam logic [3:0] S_PC   = 4'd5;
	localparam logic [3:0] S_PD   = 4'd6;
	localparam logic [3:0] S_PE   = 4'd7;
	localparam logic [3:0] S_PF   = 4'd8;
	localparam logic [3:0] S_PG   = 4'd9;
	localparam logic [3:0] S_PH   = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_PW1  = 4'd12;
	localparam logic [3:0] S_PW2  = 4'd13;
	localparam logic [3:0] S_WA   = 4'd14;
	localparam logic [3:0] S_WB   = 4'd15;

	// ---------------- configuration registers ----------------
	logic [5:0]  cfg_count_q;
	logic [9:0]  cfg_fw_q, cfg_fh_q;
	logic [7:0]  cfg_margin_q;
	logic [15:0] cfg_contact_q;
	logic [2:0]  cfg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q   <= RST_BALL_COUNT;
			cfg_fw_q      <= RST_FIELD_W;
			cfg_fh_q      <= RST_FIELD_H;
			cfg_margin_q  <= RST_MARGIN;
			cfg_contact_q <= RST_CONTACT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BALL_COUNT: cfg_count_q   <= pwdata[5:0];
				REG_FIELD_W:    cfg_fw_q      <= pwdata[9:0];
				REG_FIELD_H:    cfg_fh_q      <= pwdata[9:0];
				REG_MARGIN:     cfg_margin_q  <= pwdata[7:0];
				REG_CONTACT:    cfg_contact_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_BALL_COUNT: prdata = 32'(cfg_count_q);
			REG_FIELD_W:    prdata = 32'(cfg_fw_q);
			REG_FIELD_H:    prdata = 32'(cfg_fh_q);
			REG_MARGIN:     prdata = 32'(cfg_margin_q);
			REG_CONTACT:    prdata = 32'(cfg_contact_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- sequencer registers ----------------
	logic [3:0]    state_q;
	logic [CW-1:0] n_q, i_q, j_q, k_q;
	logic [45:0]   limit_q;
	logic [22:0]   lo_q;
	logic signed [26:0] hix_q, hiy_q;
	logic [AW-1:0] idx_q;
	logic [4:0]    ridx_q;
	logic          oor_q;
	logic [4:0]    div_cnt_q;

	logic in_acc;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	// ---------------- disc memories ----------------
	// position entry is {x, y}, velocity entry is {vx, vy}
	logic [49:0] pos_mem [MAX_DISCS];
	logic [31:0] vel_mem [MAX_DISCS];
	logic [MAX_DISCS-1:0] pos_vld_q, vel_vld_q;
	logic [49:0] pos_rdat_q;
	logic [31:0] vel_rdat_q;
	logic        pos_rv_q, vel_rv_q;

	logic [AW-1:0] rd_addr, pos_wa, vel_wa;
	logic          pos_we, vel_we;
	logic [49:0]   pos_wd;
	logic [31:0]   vel_wd;

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (vel_we) vel_mem[vel_wa] <= vel_wd;
		pos_rdat_q <= pos_mem[rd_addr];
		vel_rdat_q <= vel_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q <= '0;
			vel_vld_q <= '0;
			pos_rv_q  <= 1'b0;
			vel_rv_q  <= 1'b0;
		end else begin
			if (pos_we) pos_vld_q[pos_wa] <= 1'b1;
			if (vel_we) vel_vld_q[vel_wa] <= 1'b1;
			pos_rv_q <= pos_vld_q[rd_addr];
			vel_rv_q <= vel_vld_q[rd_addr];
		end
	end

	// entries never written read as zero
	logic [24:0] rpx, rpy;
	logic signed [15:0] rvx, rvy;
	assign rpx = pos_rv_q ? pos_rdat_q[49:25] : '0;
	assign rpy = pos_rv_q ? pos_rdat_q[24:0]  : '0;
	assign rvx = vel_rv_q ? vel_rdat_q[31:16] : '0;
	assign rvy = vel_rv_q ? vel_rdat_q[15:0]  : '0;

	logic [AW-1:0] in_addr;
	logic          in_oor;
	assign in_addr = AW'(ball_index);
	assign in_oor  = (32'(ball_index) >= 32'(MAX_DISCS));

	always_comb begin
		unique case (state_q)
			S_IDLE:      rd_addr = in_addr;
			S_RD:        rd_addr = idx_q;
			S_PA:        rd_addr = i_q[AW-1:0];
			S_PB:        rd_addr = j_q[AW-1:0];
			default:     rd_addr = k_q[AW-1:0];
		endcase
	end

	// ---------------- pair datapath ----------------
	logic [24:0] pix_q, piy_q;
	logic signed [15:0] vix_q, viy_q, vjx_q, vjy_q;
	logic [24:0] ax_q, ay_q;
	logic        ux_neg_q, uy_neg_q;
	logic [49:0] sqx_q, sqy_q;
	logic [14:0] sxm_q, sym_q;
	logic signed [16:0] dvx_q, dvy_q;
	logic signed [15:0] sx_q, sy_q;
	logic signed [32:0] prx_q, pry_q;
	logic [29:0] lx_q, ly_q;
	logic signed [33:0] d_q;
	logic [30:0] len_q;
	logic signed [49:0] numx_q, numy_q;
	logic [31:0] remx_q, remy_q;
	logic [QB-1:0] qx_q, qy_q;
	logic        nx_neg_q, ny_neg_q;

	// capture of disc j and centre line
	logic signed [25:0] ux_c, uy_c;
	assign ux_c = $signed({1'b0, rpx}) - $signed({1'b0, pix_q});
	assign uy_c = $signed({1'b0, rpy}) - $signed({1'b0, piy_q});

	// smallest shift that brings the larger magnitude below 2^15
	logic [24:0] m_c;
	logic [4:0]  msb_c;
	logic [3:0]  sh_c;
	assign m_c = (ax_q > ay_q) ? ax_q : ay_q;
	always_comb begin
		msb_c = '0;
		for (int b = 0; b < 25; b++) begin
			if (m_c[b]) msb_c = 5'(b);
		end
	end
	assign sh_c = (msb_c >= 5'd15) ? 4'(msb_c - 5'd14) : 4'd0;

	logic [51:0] dist_c;
	logic signed [15:0] sx_c, sy_c;
	assign dist_c = 52'(sqx_q) + 52'(sqy_q);
	assign sx_c = ux_neg_q ? -$signed({1'b0, sxm_q}) : $signed({1'b0, sxm_q});
	assign sy_c = uy_neg_q ? -$signed({1'b0, sym_q}) : $signed({1'b0, sym_q});

	logic signed [33:0] d_c;
	assign d_c = 34'(prx_q) + 34'(pry_q);

	// rounding divide: q = (2|num| + len) / (2 len)
	logic [48:0] anx_c, any_c;
	logic [50:0] nnx_c, nny_c;
	assign anx_c = numx_q[49] ? 49'(-numx_q) : 49'(numx_q);
	assign any_c = numy_q[49] ? 49'(-numy_q) : 49'(numy_q);
	assign nnx_c = {1'b0, anx_c, 1'b0} + 51'(len_q);
	assign nny_c = {1'b0, any_c, 1'b0} + 51'(len_q);

	logic [32:0] dden_c, tx_c, ty_c;
	logic        gex_c, gey_c;
	assign dden_c = {1'b0, len_q, 1'b0};
	assign tx_c   = {remx_q, qx_q[QB-1]};
	assign ty_c   = {remy_q, qy_q[QB-1]};
	assign gex_c  = (tx_c >= dden_c);
	assign gey_c  = (ty_c >= dden_c);

	logic signed [20:0] dresx_c, dresy_c;
	assign dresx_c = nx_neg_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
	assign dresy_c = ny_neg_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});

	logic signed [15:0] nvix_c, nviy_c, nvjx_c, nvjy_c;
	assign nvix_c = sat16(22'(vix_q) + 22'(dresx_c));
	assign nviy_c = sat16(22'(viy_q) + 22'(dresy_c));
	assign nvjx_c = sat16(22'(vjx_q) - 22'(dresx_c));
	assign nvjy_c = sat16(22'(vjy_q) - 22'(dresy_c));

	// ---------------- wall and move ----------------
	logic flipx_c, flipy_c;
	logic signed [15:0] wvx_c, wvy_c;
	logic [24:0] npx_c, npy_c;
	assign flipx_c = (25'(lo_q) >= rpx) || ($signed({2'b00, rpx}) >= hix_q);
	assign flipy_c = (25'(lo_q) >= rpy) || ($signed({2'b00, rpy}) >= hiy_q);
	assign wvx_c = flipx_c ? neg16(rvx) : rvx;
	assign wvy_c = flipy_c ? neg16(rvy) : rvy;
	assign npx_c = clamp_pos($signed({2'b00, rpx}) + 27'(wvx_c));
	assign npy_c = clamp_pos($signed({2'b00, rpy}) + 27'(wvy_c));

	// ---------------- tick set-up ----------------
	logic [CW-1:0] n_c;
	assign n_c = (32'(cfg_count_q) > 32'(MAX_DISCS)) ? CW'(MAX_DISCS) : CW'(cfg_count_q);

	// pair stepping: j advances, else i advances with j = i + 1
	logic [CW:0] j1_c, i1_c, i2_c;
	logic        more_j_c, more_i_c;
	assign j1_c = {1'b0, j_q} + 1'b1;
	assign i1_c = {1'b0, i_q} + 1'b1;
	assign i2_c = {1'b0, i_q} + 2'd2;
	assign more_j_c = (j1_c < {1'b0, n_q});
	assign more_i_c = (i2_c < {1'b0, n_q});

	// ---------------- memory writes ----------------
	always_comb begin
		pos_we = 1'b0;
		vel_we = 1'b0;
		pos_wa = k_q[AW-1:0];
		vel_wa = k_q[AW-1:0];
		pos_wd = {npx_c, npy_c};
		vel_wd = {wvx_c, wvy_c};
		unique case (state_q)
			S_IDLE: begin
				pos_wa = in_addr;
				vel_wa = in_addr;
				pos_wd = {(load_pos_x > POS_MAX) ? POS_MAX : load_pos_x,
				          (load_pos_y > POS_MAX) ? POS_MAX : load_pos_y};
				vel_wd = {load_vel_x, load_vel_y};
				pos_we = in_acc && (mode == MODE_LOAD) && !in_oor;
				vel_we = pos_we;
			end
			S_PW1: begin
				vel_we = 1'b1;
				vel_wa = i_q[AW-1:0];
				vel_wd = {nvix_c, nviy_c};
			end
			S_PW2: begin
				vel_we = 1'b1;
				vel_wa = j_q[AW-1:0];
				vel_wd = {nvjx_c, nvjy_c};
			end
			S_WB: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	logic out_vld_q;
	logic out_free;
	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_RD && out_free) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD && out_free) begin
			read_index <= ridx_q;
			read_pos_x <= oor_q ? '0 : rpx;
			read_pos_y <= oor_q ? '0 : rpy;
			read_vel_x <= oor_q ? '0 : rvx;
			read_vel_y <= oor_q ? '0 : rvy;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && mode == MODE_TICK) begin
						n_q     <= n_c;
						state_q <= S_TS;
					end else if (in_acc && mode == MODE_READ) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// hold the read address until the output register frees up
					if (out_free) state_q <= S_IDLE;
				end
				S_TS: begin
					i_q <= '0;
					j_q <= CW'(1);
					k_q <= '0;
					if (n_q >= CW'(2)) state_q <= S_PA;
					else if (n_q != '0) state_q <= S_WA;
					else state_q <= S_IDLE;
				end
				S_PA: state_q <= S_PB;
				S_PB: state_q <= S_PC;
				S_PC: state_q <= S_PD;
				S_PD: state_q <= S_PE;
				S_PE, S_PF, S_PW2: begin
					// drop the pair when out of contact, coincident or separating
					if ((state_q == S_PE && (dist_c > 52'(limit_q) ||
					     (sxm_q == '0 && sym_q == '0))) ||
					    (state_q == S_PF && d_c >= 34'sd0) || state_q == S_PW2) begin
						if (more_j_c) begin
							j_q     <= j1_c[CW-1:0];
							state_q <= S_PA;
						end else if (more_i_c) begin
							i_q     <= i1_c[CW-1:0];
							j_q     <= i2_c[CW-1:0];
							state_q <= S_PA;
						end else begin
							k_q     <= '0;
							state_q <= S_WA;
						end
					end else if (state_q == S_PE) begin
						state_q <= S_PF;
					end else begin
						state_q <= S_PG;
					end
				end
				S_PG: state_q <= S_PH;
				S_PH: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(QB - 1)) state_q <= S_PW1;
				end
				S_PW1: state_q <= S_PW2;
				S_WA:  state_q <= S_WB;
				S_WB: begin
					if ({1'b0, k_q} + 1'b1 >= {1'b0, n_q}) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_WA;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			limit_q <= 46'(cfg_contact_q * SUB_PER_PIX2);
			lo_q    <= 23'(cfg_margin_q * SUB_PER_PIX);
			hix_q   <= 27'(($signed({1'b0, cfg_fw_q}) - $signed({3'b000, cfg_margin_q}))
			           * $signed({1'b0, SUB_PER_PIX}));
			hiy_q   <= 27'(($signed({1'b0, cfg_fh_q}) - $signed({3'b000, cfg_margin_q}))
			           * $signed({1'b0, SUB_PER_PIX}));
			idx_q   <= in_addr;
			ridx_q  <= ball_index;
			oor_q   <= in_oor;
		end
		unique case (state_q)
			S_PB: begin
				pix_q <= rpx;
				piy_q <= rpy;
				vix_q <= rvx;
				viy_q <= rvy;
			end
			S_PC: begin
				vjx_q    <= rvx;
				vjy_q    <= rvy;
				ux_neg_q <= ux_c[25];
				uy_neg_q <= uy_c[25];
				ax_q     <= ux_c[25] ? 25'(-ux_c) : ux_c[24:0];
				ay_q     <= uy_c[25] ? 25'(-uy_c) : uy_c[24:0];
			end
			S_PD: begin
				sqx_q <= ax_q * ax_q;
				sqy_q <= ay_q * ay_q;
				sxm_q <= 15'(ax_q >> sh_c);
				sym_q <= 15'(ay_q >> sh_c);
				dvx_q <= 17'(vjx_q) - 17'(vix_q);
				dvy_q <= 17'(vjy_q) - 17'(viy_q);
			end
			S_PE: begin
				sx_q  <= sx_c;
				sy_q  <= sy_c;
				prx_q <= dvx_q * sx_c;
				pry_q <= dvy_q * sy_c;
				lx_q  <= sxm_q * sxm_q;
				ly_q  <= sym_q * sym_q;
			end
			S_PF: begin
				d_q   <= d_c;
				len_q <= 31'(lx_q) + 31'(ly_q);
			end
			S_PG: begin
				numx_q <= d_q * sx_q;
				numy_q <= d_q * sy_q;
			end
			S_PH: begin
				nx_neg_q <= numx_q[49];
				ny_neg_q <= numy_q[49];
				remx_q   <= 32'(nnx_c[50:QB]);
				remy_q   <= 32'(nny_c[50:QB]);
				qx_q     <= nnx_c[QB-1:0];
				qy_q     <= nny_c[QB-1:0];
			end
			S_DIV: begin
				// one restoring step: shift in the next dividend bit, take the quotient bit
				remx_q <= gex_c ? 32'(tx_c - dden_c) : tx_c[31:0];
				remy_q <= gey_c ? 32'(ty_c - dden_c) : ty_c[31:0];
				qx_q   <= {qx_q[QB-2:0], gex_c};
				qy_q   <= {qy_q[QB-2:0], gey_c};
			end
			default: ;
		endcase
	end

endmodule
